/* rtl/trapezoid_profile_timing_core_defines.svh */
// Assertion macros for the trapezoid profile timing core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef TRAPEZOID_PROFILE_TIMING_CORE_DEFINES_SVH
`define TRAPEZOID_PROFILE_TIMING_CORE_DEFINES_SVH
`ifndef SYNTH
`define TPT_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TPT_ASSERT_NORST(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPT_ASSERT(name, prop, msg)
`define TPT_ASSERT_NORST(name, prop, msg)
`endif
`endif

/* rtl/tpt_pkg.sv */
// Shared constants and types of the trapezoid profile timing core.
// No dependencies.
package tpt_pkg;
	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_ACCEL = 3'd0;
	localparam int ACCEL_RESET_MM = 3000;

	typedef struct packed {
		logic en;
		logic vld;
	} tpt_ctl_t;
endpackage

/* rtl/tpt_if.sv */
// Valid/ready channel interfaces: move words in, profile words out.
// No dependencies.
interface tpt_move_if #(parameter int VALUE_WIDTH = 32);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] move_length;
	logic [VALUE_WIDTH-1:0] entry_speed;
	logic [VALUE_WIDTH-1:0] target_speed;
	logic [VALUE_WIDTH-1:0] exit_speed;
	modport source(output valid, move_length, entry_speed, target_speed, exit_speed,
		input ready);
	modport sink(input valid, move_length, entry_speed, target_speed, exit_speed,
		output ready);
endinterface

interface tpt_profile_if #(parameter int VALUE_WIDTH = 32);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] accel_time;
	logic [VALUE_WIDTH-1:0] cruise_time;
	logic [VALUE_WIDTH-1:0] decel_time;
	logic                   saturated;
	modport source(output valid, accel_time, cruise_time, decel_time, saturated,
		input ready);
	modport sink(input valid, accel_time, cruise_time, decel_time, saturated,
		output ready);
endinterface

/* rtl/tpt_div.sv */
// Pipelined restoring divider, one quotient bit per stage, saturating.
// Depends on tpt_pkg for the stage control struct.
module tpt_div #(
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int QW = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tpt_pkg::tpt_ctl_t  ctl,
	input  logic [NW-1:0]      num,
	input  logic [DW-1:0]      den,
	output logic               vld,
	output logic [QW-1:0]      q,
	output logic               sat
);
	import tpt_pkg::*;

	localparam int CW = ((NW > DW) ? NW : DW) + 1;

	logic [QW:0]    vld_s;
	logic [QW:0]    sat_s;
	logic [DW-1:0]  rem_s [QW+1];
	logic [DW-1:0]  den_s [QW+1];
	logic [QW-1:0]  lo_s  [QW+1];
	logic [QW-1:0]  quo_s [QW+1];

	logic [CW-1:0]  hi_x;
	logic [CW-1:0]  den_x;
	logic           sat0;

	assign hi_x  = CW'(num >> QW);
	assign den_x = CW'(den);
	assign sat0  = (den == '0) || (hi_x >= den_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (ctl.en) begin
			vld_s[0] <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sat_s[0] <= sat0;
			rem_s[0] <= sat0 ? '0 : DW'(hi_x);
			den_s[0] <= den;
			lo_s[0]  <= num[QW-1:0];
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [DW:0] trial;
		logic        ge;

		assign trial = {rem_s[k-1], lo_s[k-1][QW-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				sat_s[k] <= sat_s[k-1];
				rem_s[k] <= DW'(ge ? trial - {1'b0, den_s[k-1]} : trial);
				den_s[k] <= den_s[k-1];
				lo_s[k]  <= lo_s[k-1] << 1;
				quo_s[k] <= {quo_s[k-1][QW-2:0], ge};
			end
		end
	end

	assign vld = vld_s[QW];
	assign sat = sat_s[QW];
	assign q   = sat_s[QW] ? '1 : quo_s[QW];
endmodule

/* rtl/trapezoid_profile_timing_core.sv */
// Top level of the trapezoid profile timing core: products, fit test, square root, dividers.
// Depends on tpt_pkg, tpt_if interfaces, tpt_div and the assertion macro header.
//
// Usage: one move word (length, entry, target, exit speed) enters on the move channel
// and one profile word (accel, cruise, decel time and a saturation flag) leaves on the
// profile channel, in the same order. Both channels are valid/ready.
// Acceleration is set over the APB port at address 0; the user must write it only while
// the core is empty, as the core itself does not enforce this. Throughput: one move per
// cycle while the receiver takes each output word. Words pass the square root pipeline of
// VALUE_WIDTH+1 stages followed by the divider pipelines of VALUE_WIDTH+1 stages.
// Reset empties the pipeline and loads 3000 mm/s^2 into the acceleration register.
// When the receiver stalls, the output register holds its word and the whole pipeline
// freezes; move.ready drops until the output word is taken, nothing is lost or repeated.
`include "trapezoid_profile_timing_core_defines.svh"
module trapezoid_profile_timing_core #(
	parameter int VALUE_WIDTH = 32,
	parameter int FRAC_BITS   = 16,
	localparam int PDATA_W    = (VALUE_WIDTH > 32) ? 64 : 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tpt_move_if.sink                     move,
	tpt_profile_if.source                profile,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tpt_pkg::PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]           pwdata,
	output logic [PDATA_W-1:0]           prdata,
	output logic                         pready
);
	import tpt_pkg::*;

	localparam int W    = VALUE_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int PW   = W + 1;
	localparam int RW   = 2 * W + 1;
	localparam int RPAD = 2 * PW;
	localparam int REMW = PW + 2;
	localparam int ANW  = PW + F;
	localparam int CNW  = 2 * W + 1 + F;
	localparam int CDW  = 2 * W + 1;
	localparam logic [W-1:0] ACCEL_RST = W'(64'(ACCEL_RESET_MM) << F);

	typedef struct packed {
		logic [W-1:0]   s;
		logic [W-1:0]   e;
		logic [W-1:0]   c;
		logic [W-1:0]   a;
		logic           fit;
		logic [CNW-1:0] cnum;
		logic [CDW-1:0] cden;
	} carry_t;

	logic         en;
	logic [W-1:0] acc_q;

	assign pready = 1'b1;
	assign prdata = PDATA_W'(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= ACCEL_RST;
		end else if (psel && penable && pwrite && paddr == ADDR_ACCEL) begin
			acc_q <= pwdata[W-1:0];
		end
	end

	// stage 1: capture
	logic         vld_s1;
	logic [W-1:0] d_s1, s_s1, c_s1, e_s1, a_s1;

	// stage 2: products
	logic           vld_s2;
	logic [2*W-1:0] sq_s2, eq_s2, cq_s2, ad_s2, ac_s2;
	logic [W-1:0]   d_s2, s_s2, c_s2, e_s2, a_s2;

	// stage 3: ramp terms
	logic           vld_s3;
	logic [2*W-1:0] r1_s3, r2_s3;
	logic [2*W:0]   ad2_s3, rs_s3, ac2_s3;
	logic [W-1:0]   d_s3, s_s3, c_s3, e_s3, a_s3;

	// stage 4: ramp sum
	logic           vld_s4;
	logic [2*W:0]   ramps_s4, ad2_s4, rs_s4, ac2_s4;
	logic [W-1:0]   d_s4, s_s4, c_s4, e_s4, a_s4;

	// stage 5: fit test, radicand, cruise operands
	logic           vld_s5;
	carry_t         cr_s5;
	logic [RW-1:0]  rad_s5;
	logic [2*W+1:0] radsum;
	logic           rz;

	assign en         = !profile.valid || profile.ready;
	assign move.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= move.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign radsum = {1'b0, rs_s4} + {1'b0, ad2_s4};
	assign rz     = (ramps_s4 == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= move.move_length;
			s_s1 <= move.entry_speed;
			c_s1 <= move.target_speed;
			e_s1 <= move.exit_speed;
			a_s1 <= acc_q;

			sq_s2 <= s_s1 * s_s1;
			eq_s2 <= e_s1 * e_s1;
			cq_s2 <= c_s1 * c_s1;
			ad_s2 <= a_s1 * d_s1;
			ac_s2 <= a_s1 * c_s1;
			{d_s2, s_s2, c_s2, e_s2, a_s2} <= {d_s1, s_s1, c_s1, e_s1, a_s1};

			r1_s3  <= (c_s2 > s_s2) ? cq_s2 - sq_s2 : '0;
			r2_s3  <= (c_s2 > e_s2) ? cq_s2 - eq_s2 : '0;
			ad2_s3 <= {ad_s2, 1'b0};
			rs_s3  <= {1'b0, sq_s2} + {1'b0, eq_s2};
			ac2_s3 <= {ac_s2, 1'b0};
			{d_s3, s_s3, c_s3, e_s3, a_s3} <= {d_s2, s_s2, c_s2, e_s2, a_s2};

			ramps_s4 <= {1'b0, r1_s3} + {1'b0, r2_s3};
			ad2_s4   <= ad2_s3;
			rs_s4    <= rs_s3;
			ac2_s4   <= ac2_s3;
			{d_s4, s_s4, c_s4, e_s4, a_s4} <= {d_s3, s_s3, c_s3, e_s3, a_s3};

			cr_s5.s    <= s_s4;
			cr_s5.e    <= e_s4;
			cr_s5.c    <= c_s4;
			cr_s5.a    <= a_s4;
			cr_s5.fit  <= ramps_s4 <= ad2_s4;
			cr_s5.cnum <= rz ? CNW'({d_s4, {F{1'b0}}}) : {ad2_s4 - ramps_s4, {F{1'b0}}};
			cr_s5.cden <= rz ? CDW'(c_s4) : ac2_s4;
			rad_s5     <= radsum[2*W+1:1];
		end
	end

	// square root, two radicand bits per stage
	logic [PW-1:0]   vld_sq;
	carry_t          cr_sq   [PW];
	logic [REMW-1:0] rem_sq  [PW];
	logic [PW-1:0]   root_sq [PW];
	logic [RPAD-1:0] rad_sq  [PW];

	for (genvar k = 0; k < PW; k++) begin : g_sq
		logic            v_in;
		carry_t          cr_in;
		logic [REMW-1:0] rem_in;
		logic [PW-1:0]   root_in;
		logic [RPAD-1:0] rad_in;
		logic [REMW:0]   rem2;
		logic [REMW:0]   trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign v_in    = vld_s5;
			assign cr_in   = cr_s5;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = {1'b0, rad_s5};
		end else begin : g_next
			assign v_in    = vld_sq[k-1];
			assign cr_in   = cr_sq[k-1];
			assign rem_in  = rem_sq[k-1];
			assign root_in = root_sq[k-1];
			assign rad_in  = rad_sq[k-1];
		end

		assign rem2  = {rem_in[REMW-2:0], rad_in[RPAD-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign ge    = rem2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq[k] <= 1'b0;
			end else if (en) begin
				vld_sq[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cr_sq[k]   <= cr_in;
				rem_sq[k]  <= REMW'(ge ? rem2 - trial : rem2);
				root_sq[k] <= {root_in[PW-2:0], ge};
				rad_sq[k]  <= rad_in << 2;
			end
		end
	end

	// stage 6: clamp peak, build divider operands
	carry_t         cl;
	logic [PW-1:0]  p_max, hi_a, hi_d, diff_a, diff_d;
	logic           ramp_a, ramp_d;
	logic           vld_s6;
	logic [ANW-1:0] num_a_s6, num_d_s6;
	logic [W-1:0]   den_a_s6, den_d_s6;
	logic [CNW-1:0] num_c_s6;
	logic [CDW-1:0] den_c_s6;

	assign cl = cr_sq[PW-1];

	always_comb begin
		p_max = root_sq[PW-1];
		if ({1'b0, cl.s} > p_max) begin
			p_max = {1'b0, cl.s};
		end
		if ({1'b0, cl.e} > p_max) begin
			p_max = {1'b0, cl.e};
		end
		hi_a   = cl.fit ? {1'b0, cl.c} : p_max;
		hi_d   = cl.fit ? {1'b0, cl.c} : p_max;
		ramp_a = hi_a > {1'b0, cl.s};
		ramp_d = hi_d > {1'b0, cl.e};
		diff_a = hi_a - {1'b0, cl.s};
		diff_d = hi_d - {1'b0, cl.e};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_sq[PW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_a_s6 <= ramp_a ? {diff_a, {F{1'b0}}} : '0;
			den_a_s6 <= ramp_a ? cl.a : W'(1);
			num_d_s6 <= ramp_d ? {diff_d, {F{1'b0}}} : '0;
			den_d_s6 <= ramp_d ? cl.a : W'(1);
			num_c_s6 <= cl.fit ? cl.cnum : '0;
			den_c_s6 <= cl.fit ? cl.cden : CDW'(1);
		end
	end

	tpt_ctl_t     div_ctl;
	logic         div_vld_a, div_vld_c, div_vld_d;
	logic [W-1:0] q_a, q_c, q_d;
	logic         sat_a, sat_c, sat_d;

	assign div_ctl = '{en: en, vld: vld_s6};

	tpt_div #(.NW(ANW), .DW(W), .QW(W)) u_div_accel (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .num(num_a_s6), .den(den_a_s6),
		.vld(div_vld_a), .q(q_a), .sat(sat_a)
	);

	tpt_div #(.NW(CNW), .DW(CDW), .QW(W)) u_div_cruise (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .num(num_c_s6), .den(den_c_s6),
		.vld(div_vld_c), .q(q_c), .sat(sat_c)
	);

	tpt_div #(.NW(ANW), .DW(W), .QW(W)) u_div_decel (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .num(num_d_s6), .den(den_d_s6),
		.vld(div_vld_d), .q(q_d), .sat(sat_d)
	);

	// output register
	logic         out_vld_q;
	logic [W-1:0] at_q, ct_q, dt_q;
	logic         sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= div_vld_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			at_q  <= q_a;
			ct_q  <= q_c;
			dt_q  <= q_d;
			sat_q <= sat_a || sat_c || sat_d;
		end
	end

	assign profile.valid       = out_vld_q;
	assign profile.accel_time  = at_q;
	assign profile.cruise_time = ct_q;
	assign profile.decel_time  = dt_q;
	assign profile.saturated   = sat_q;

	`TPT_ASSERT(a_sat_clamps, out_vld_q && sat_q |-> (at_q == '1 || ct_q == '1 || dt_q == '1), "saturated word without a clamped time")
	`TPT_ASSERT(a_stall_freezes, !en |=> $stable({vld_s1, vld_s5, vld_sq, vld_s6}), "pipeline moved while stalled")
	`TPT_ASSERT(a_drain_to_out, en && div_vld_a |=> out_vld_q, "divider word not captured")
	`TPT_ASSERT(a_div_lockstep, div_vld_a == div_vld_c && div_vld_a == div_vld_d, "dividers out of step")
	`TPT_ASSERT(a_cfg_write, psel && penable && pwrite && paddr == ADDR_ACCEL |=> acc_q == $past(pwdata[W-1:0]), "acceleration write lost")
	`TPT_ASSERT_NORST(a_rst_empty, !arst_n |=> !out_vld_q, "output valid during reset")
endmodule
